>>> design/orqm_pkg.sv
// Shared types and constants for the overwriting ring queue with mean.
`timescale 1ns / 1ps
`default_nettype none
package orqm_pkg;

  localparam int QUEUE_SLOTS_DEF = 6;
  localparam int ID_W            = 12;
  localparam int HEIGHT_W        = 9;
  localparam int KIND_W          = 2;
  // mean never exceeds the largest height, so the quotient fits a height
  localparam int QUOT_W          = HEIGHT_W;
  localparam int ITER_W          = $clog2(QUOT_W);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERTED = 2'd0,
    KIND_REMOVED  = 2'd1,
    KIND_EMPTY    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_step;
    logic load_out;
  } orqm_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic div_last;
    logic out_hold;
  } orqm_status_t;

endpackage
`default_nettype wire

>>> design/orqm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module orqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/orqm_ctrl.sv
// Sequencing state machine: read, update, divide, hand off result.
`timescale 1ns / 1ps
`default_nettype none
module orqm_ctrl
  import orqm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire orqm_status_t stat,
  output orqm_cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = stat.is_insert ? ST_DIV : ST_DONE;
      ST_DIV:  if (stat.div_last) state_nxt = ST_DONE;
      ST_DONE: if (!stat.out_hold) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_READ: ;
      ST_EXEC: cmd.exec = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_DONE: cmd.load_out = !stat.out_hold;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_exec_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $past(state_r) == ST_READ)
    else $error("update issued without a preceding slot read");
  a_div_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !stat.is_insert) |=> !cmd.div_step)
    else $error("division started for a remove");
  a_no_overwrite_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && stat.out_hold) |=> state_r == ST_DONE)
    else $error("left result stage while output still held");
`endif

endmodule
`default_nettype wire

>>> design/orqm_dp.sv
// Datapath: slot RAM, ring pointers, running sum, divider, output register.
`timescale 1ns / 1ps
`default_nettype none
module orqm_dp
  import orqm_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire orqm_cmd_t           cmd,
  output orqm_status_t             stat,
  input  wire logic                in_opcode,
  input  wire logic [ID_W-1:0]     in_entry_id,
  input  wire logic [HEIGHT_W-1:0] in_entry_height,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [KIND_W-1:0]        out_result_kind,
  output logic [HEIGHT_W-1:0]      out_mean_height,
  output logic [ID_W-1:0]          out_removed_id,
  output logic [HEIGHT_W-1:0]      out_removed_height
);

  localparam int IDX_W = $clog2(QUEUE_SLOTS);
  localparam int CNT_W = IDX_W;
  localparam int SUM_W = HEIGHT_W + CNT_W;
  localparam int REM_W = SUM_W + 2;
  localparam int ENT_W = ID_W + HEIGHT_W;

  // captured item
  op_t                 op_r;
  logic [ID_W-1:0]     id_r;
  logic [HEIGHT_W-1:0] hgt_r;

  // queue state
  logic [IDX_W-1:0] head_r, head_nxt, tail_r, tail_nxt, head_inc, tail_inc;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // pending result
  kind_t               res_kind_r, res_kind_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic [HEIGHT_W-1:0] res_hgt_r, res_hgt_nxt;

  // divider
  logic [REM_W-1:0]  rem_r, dsh_r;
  logic [QUOT_W-1:0] quot_r;
  logic [ITER_W-1:0] iter_r;

  // output register
  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [HEIGHT_W-1:0] out_mean_r, out_hgt_r;
  logic [ID_W-1:0]     out_id_r;

  logic                ram_we;
  logic [ENT_W-1:0]    ram_rdata;
  logic [ID_W-1:0]     rd_id;
  logic [HEIGHT_W-1:0] rd_hgt;
  logic                empty, full;

  orqm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata ({id_r, hgt_r}),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign rd_id  = ram_rdata[ENT_W-1:HEIGHT_W];
  assign rd_hgt = ram_rdata[HEIGHT_W-1:0];

  assign head_inc = (head_r == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : tail_r + 1'b1;
  assign empty    = (head_r == tail_r);
  assign full     = (tail_inc == head_r);

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    ram_we       = 1'b0;
    res_kind_nxt = res_kind_r;
    res_id_nxt   = res_id_r;
    res_hgt_nxt  = res_hgt_r;
    if (cmd.exec) begin
      if (op_r == OP_REMOVE) begin
        if (empty) begin
          res_kind_nxt = KIND_EMPTY;
          res_id_nxt   = '0;
          res_hgt_nxt  = '0;
        end else begin
          res_kind_nxt = KIND_REMOVED;
          res_id_nxt   = rd_id;
          res_hgt_nxt  = rd_hgt;
          head_nxt     = head_inc;
          sum_nxt      = sum_r - SUM_W'(rd_hgt);
          cnt_nxt      = cnt_r - 1'b1;
        end
      end else begin
        res_kind_nxt = KIND_INSERTED;
        res_id_nxt   = '0;
        res_hgt_nxt  = '0;
        ram_we       = 1'b1;
        tail_nxt     = tail_inc;
        if (full) begin
          // oldest entry drops out silently
          head_nxt = head_inc;
          sum_nxt  = sum_r - SUM_W'(rd_hgt) + SUM_W'(hgt_r);
        end else begin
          sum_nxt  = sum_r + SUM_W'(hgt_r);
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_t'(in_opcode);
      id_r  <= in_entry_id;
      hgt_r <= in_entry_height;
    end
    res_kind_r <= res_kind_nxt;
    res_id_r   <= res_id_nxt;
    res_hgt_r  <= res_hgt_nxt;
  end

  // Restoring division of (2*sum + count) by (2*count), one quotient bit per step.
  // Divisor starts at (2*count) << (QUOT_W-1) == count << QUOT_W.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rem_r  <= {sum_nxt, 1'b0} + REM_W'(cnt_nxt);
      dsh_r  <= REM_W'(cnt_nxt) << QUOT_W;
      quot_r <= '0;
      iter_r <= ITER_W'(QUOT_W - 1);
    end else if (cmd.div_step) begin
      if (rem_r >= dsh_r) begin
        rem_r  <= rem_r - dsh_r;
        quot_r <= {quot_r[QUOT_W-2:0], 1'b1};
      end else begin
        quot_r <= {quot_r[QUOT_W-2:0], 1'b0};
      end
      dsh_r  <= dsh_r >> 1;
      iter_r <= iter_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind_r <= res_kind_r;
      out_mean_r <= (res_kind_r == KIND_INSERTED) ? quot_r : '0;
      out_id_r   <= res_id_r;
      out_hgt_r  <= res_hgt_r;
    end
  end

  assign stat.is_insert = (op_r == OP_INSERT);
  assign stat.div_last  = (iter_r == '0);
  assign stat.out_hold  = out_valid_r && !out_ready;

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_mean_height    = out_mean_r;
  assign out_removed_id     = out_id_r;
  assign out_removed_height = out_hgt_r;

`ifndef ASSERT_OFF
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= IDX_W'(QUEUE_SLOTS - 1)) && (tail_r <= IDX_W'(QUEUE_SLOTS - 1)))
    else $error("ring pointer out of range");
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r >= head_r) ? (int'(cnt_r) == int'(tail_r) - int'(head_r))
                       : (int'(cnt_r) == QUEUE_SLOTS + int'(tail_r) - int'(head_r)))
    else $error("entry count disagrees with pointers");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> ({1'b0, rem_r} < ({1'b0, dsh_r} << 1)))
    else $error("partial remainder exceeds divisor bound");
`endif

endmodule
`default_nettype wire

>>> design/overwriting_ring_queue_with_mean.sv
// Overwriting ring queue with mean height: top level.
//
// Input channel (in_valid/in_ready): in_opcode 0 inserts in_entry_id and
// in_entry_height, dropping the oldest entry when QUEUE_SLOTS-1 are held;
// in_opcode 1 pops the oldest entry.
// Output channel (out_valid/out_ready): one result per input transfer.
// out_result_kind 0 gives the rounded-half-up mean height after an insert,
// 1 gives the popped id and height, 2 flags a remove on an empty queue.
// An insert's result passes through the registered read of the oldest slot,
// the queue update, the divider, which resolves one quotient bit per cycle,
// and the load of the output register; a remove skips the divider. The next
// item can transfer only after the return to idle that follows the load.
// The finished result sits in an output register, so the next item is taken
// while it waits; a further result waits until that register is emptied.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; slot contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none
module overwriting_ring_queue_with_mean
  import orqm_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_opcode,
  input  wire logic [ID_W-1:0]     in_entry_id,
  input  wire logic [HEIGHT_W-1:0] in_entry_height,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [KIND_W-1:0]        out_result_kind,
  output logic [HEIGHT_W-1:0]      out_mean_height,
  output logic [ID_W-1:0]          out_removed_id,
  output logic [HEIGHT_W-1:0]      out_removed_height
);

  orqm_cmd_t    cmd;
  orqm_status_t stat;

  orqm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  orqm_dp #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_opcode),
    .in_entry_id        (in_entry_id),
    .in_entry_height    (in_entry_height),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_mean_height    (out_mean_height),
    .out_removed_id     (out_removed_id),
    .out_removed_height (out_removed_height)
  );

endmodule
`default_nettype wire

>>> tb/sv/orqm_checker.sv
// Checker for the overwriting ring queue: predicts each result and compares.
`timescale 1ns / 1ps
module orqm_checker
  import orqm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_opcode,
  input  logic [ID_W-1:0]     in_entry_id,
  input  logic [HEIGHT_W-1:0] in_entry_height,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [KIND_W-1:0]   out_result_kind,
  input  logic [HEIGHT_W-1:0] out_mean_height,
  input  logic [ID_W-1:0]     out_removed_id,
  input  logic [HEIGHT_W-1:0] out_removed_height,
  output int                  fail_count,
  output int                  outstanding
);

  localparam int SLOTS = QUEUE_SLOTS_DEF;

  typedef struct packed {
    kind_t               kind;
    logic [HEIGHT_W-1:0] mean;
    logic [ID_W-1:0]     id;
    logic [HEIGHT_W-1:0] height;
  } ring_result_t;

  logic [ID_W-1:0]     ring_id     [SLOTS];
  logic [HEIGHT_W-1:0] ring_height [SLOTS];
  int                  head;
  int                  tail;
  ring_result_t        pending_results[$];
  ring_result_t        want;

  function automatic int wrap_next(input int i);
    return (i + 1 >= SLOTS) ? 0 : i + 1;
  endfunction

  // Applies one transfer to the predicted queue and returns its result.
  function automatic ring_result_t ring_step(input op_t op, input logic [ID_W-1:0] id,
                                             input logic [HEIGHT_W-1:0] h);
    ring_result_t r;
    int unsigned  sum;
    int unsigned  cnt;
    int           i;
    r = '0;
    if (op == OP_REMOVE) begin
      if (head == tail) begin
        r.kind = KIND_EMPTY;
      end else begin
        r.kind   = KIND_REMOVED;
        r.id     = ring_id[head];
        r.height = ring_height[head];
        head     = wrap_next(head);
      end
      return r;
    end
    // full: oldest entry is dropped without notice
    if (wrap_next(tail) == head) head = wrap_next(head);
    ring_id[tail]     = id;
    ring_height[tail] = h;
    tail = wrap_next(tail);
    sum = 0;
    cnt = 0;
    for (i = head; i != tail; i = wrap_next(i)) begin
      sum += ring_height[i];
      cnt++;
    end
    r.kind = KIND_INSERTED;
    r.mean = HEIGHT_W'((2 * sum + cnt) / (2 * cnt));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    $display("MISMATCH %0t: %s got %0d expected %0d", $time, what, got, exp_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head = 0;
      tail = 0;
      pending_results.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (in_valid && in_ready)
        pending_results.push_back(ring_step(op_t'(in_opcode), in_entry_id, in_entry_height));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding, kind", out_result_kind, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_result_kind !== want.kind)
            report_mismatch("result_kind", out_result_kind, want.kind);
          if (out_mean_height !== want.mean)
            report_mismatch("mean_height", out_mean_height, want.mean);
          if (out_removed_id !== want.id)
            report_mismatch("removed_id", out_removed_id, want.id);
          if (out_removed_height !== want.height)
            report_mismatch("removed_height", out_removed_height, want.height);
        end
      end
      outstanding <= outstanding + int'(in_valid && in_ready) - int'(out_valid && out_ready);
    end
  end

endmodule

>>> tb/sv/overwriting_ring_queue_with_mean_test.sv
// Testbench top for the overwriting ring queue: stimulus, output stalls, verdict.
`timescale 1ns / 1ps
module overwriting_ring_queue_with_mean_test;
  import orqm_pkg::*;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int RANDOM_ITEMS = 530;
  localparam int LONG_HOLD    = 150;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_opcode;
  logic [ID_W-1:0]     in_entry_id;
  logic [HEIGHT_W-1:0] in_entry_height;
  logic                out_valid;
  logic                out_ready;
  logic [KIND_W-1:0]   out_result_kind;
  logic [HEIGHT_W-1:0] out_mean_height;
  logic [ID_W-1:0]     out_removed_id;
  logic [HEIGHT_W-1:0] out_removed_height;
  int                  fail_count;
  int                  outstanding;

  int                  cycle_count = 0;
  int                  n_insert = 0;
  int                  n_remove = 0;
  bit                  sender_calm = 1'b0;

  always #5 clk = ~clk;

  overwriting_ring_queue_with_mean uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_entry_id(in_entry_id), .in_entry_height(in_entry_height),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_mean_height(out_mean_height), .out_removed_id(out_removed_id),
    .out_removed_height(out_removed_height)
  );

  orqm_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_entry_id(in_entry_id), .in_entry_height(in_entry_height),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_mean_height(out_mean_height), .out_removed_id(out_removed_id),
    .out_removed_height(out_removed_height),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // Returns at the edge where the item transfers; valid stays high until the next call.
  task automatic send_item(input op_t op, input logic [ID_W-1:0] id,
                           input logic [HEIGHT_W-1:0] h);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_entry_id     <= id;
    in_entry_height <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_INSERT) n_insert++;
    else n_remove++;
  endtask

  task automatic insert_entry(input logic [ID_W-1:0] id, input logic [HEIGHT_W-1:0] h);
    send_item(OP_INSERT, id, h);
  endtask

  task automatic remove_oldest();
    send_item(OP_REMOVE, ID_W'($urandom_range(0, 4095)), HEIGHT_W'($urandom_range(0, 511)));
  endtask

  // Sender stops and waits until every outstanding result has transferred.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [HEIGHT_W-1:0] pick_height();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return HEIGHT_W'($urandom_range(0, 511));
    endcase
  endfunction

  // Receiver: random stalls per result, calm stretches, two long holds.
  initial begin : receiver
    int got;
    int stall;
    bit calm;
    got  = 0;
    calm = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (got == 60 || got == 330) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (got % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got++;
    end
  end

  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int ins_pct;
    int k;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_INSERT;
    in_entry_id     <= '0;
    in_entry_height <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, field extremes, overwrite when full, drain to empty, rounding
    remove_oldest();
    insert_entry(12'h000, 9'd0);
    insert_entry(12'hFFF, 9'd511);
    insert_entry(12'hAAA, 9'd1);
    insert_entry(12'h555, 9'd2);
    insert_entry(12'h0F0, 9'd510);
    insert_entry(12'hF0F, 9'd511);
    insert_entry(12'h001, 9'd256);
    insert_entry(12'h800, 9'd255);
    repeat (6) remove_oldest();
    insert_entry(12'h003, 9'd1);
    insert_entry(12'h004, 9'd2);
    repeat (3) remove_oldest();
    drain();

    // random: blocks mostly alternate insert-heavy and remove-heavy so full and empty recur
    ins_pct = 70;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 50 == 0) begin
        ins_pct     = (ins_pct > 50) ? 30 : 75;
        if ($urandom_range(0, 4) == 0) ins_pct = 50;
        sender_calm = ($urandom_range(0, 3) == 0);
      end
      if (k == RANDOM_ITEMS / 2) drain();
      if ($urandom_range(1, 100) <= ins_pct)
        insert_entry(ID_W'($urandom_range(0, 4095)), pick_height());
      else
        remove_oldest();
    end
    drain();
    repeat (30) @(posedge clk);

    $display("run covered %0d transfers in: %0d inserts, %0d removes, %0d cycles",
             n_insert + n_remove, n_insert, n_remove, cycle_count);
    $display("with two long output holds, three sender drains, %0d mismatches", fail_count);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
